@@ rtl/core/cccv_battery_current_controller_top_defines.svh @@
// Assertion macros for the CC/CV charge controller
`ifndef CCCV_BATTERY_CURRENT_CONTROLLER_TOP_DEFINES_SVH
`define CCCV_BATTERY_CURRENT_CONTROLLER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define CCCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CCCV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`define CCCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define CCCV_ASSERT(lbl, prop, msg)
`define CCCV_ASSERT_IMPL(lbl, ante, cons, msg)
`define CCCV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/cccv_pkg.sv @@
// Types and constants of the CC/CV charge controller
package cccv_pkg;

  localparam int CalcW   = 20;
  localparam int InDataW = 48;
  localparam int OutDataW = 72;

  typedef logic signed [CalcW-1:0] calc_t;

  typedef enum logic [2:0] {
    KIND_TICK       = 3'd0,
    KIND_START_CHA  = 3'd1,
    KIND_START_DSCH = 3'd2,
    KIND_STOP       = 3'd3,
    KIND_SET_CUR    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_CHA   = 2'd1,
    MODE_DSCH  = 2'd2,
    MODE_FAULT = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    FLT_NONE       = 3'd0,
    FLT_CHA_RANGE  = 3'd1,
    FLT_CHA_LEVEL  = 3'd2,
    FLT_DSCH_RANGE = 3'd3,
    FLT_DSCH_LEVEL = 3'd4,
    FLT_CHA_LOOP   = 3'd5,
    FLT_DSCH_LOOP  = 3'd6
  } fault_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_PARAM  = 2'd1,
    STS_SIGN   = 2'd2,
    STS_NO_CMD = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_VOLT_TARGET = 2'd0,
    CFG_STOP_VOLT   = 2'd1,
    CFG_STOP_CUR    = 2'd2,
    CFG_MID_TRIM    = 2'd3
  } cfg_idx_e;

  localparam calc_t MidPoint   = 20'sd31768;
  localparam calc_t MaxPosI    = 20'sd29000;
  localparam calc_t MinNegI    = -20'sd29000;
  localparam calc_t TrimMax    = 20'sd2000;
  localparam calc_t TrimMin    = -20'sd2000;
  localparam calc_t MTrimLim   = 20'sd1000;
  localparam calc_t IdleSpan   = 20'sd2000;
  localparam calc_t FaultSpan  = 20'sd1000;
  localparam calc_t Deadband   = 20'sd2;
  localparam calc_t ReqLim     = 20'sd25000;
  localparam int    TrimShift  = 3;
  localparam logic [4:0] SettleReload = 5'd20;

  localparam logic [12:0] VoltTargetRst = 13'd3300;

endpackage

@@ rtl/core/cccv_battery_current_controller_top.sv @@
// CC/CV charge and discharge controller: command and tick processing
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   tvalid/tready             tuser kind, tdata measurements/request
// m_axis    out  tvalid/tready             tdata status, levels, target, trim
// cfg       in   cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled; an accepted item is
// registered in the input register, then in the result register, from which it is taken.
// The input register and the result register each hold one item; the controller
// state is updated in the same cycle the result register is loaded.
// A stalled output holds the result register and then the input register.
// Reset: off, target 0, trim 0, settle count 20, levels 33768/29768.
`include "cccv_battery_current_controller_top_defines.svh"

module cccv_battery_current_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] measured_voltage, [31:16] measured_current, [47:32] current_request
  input  logic [cccv_pkg::InDataW-1:0]  s_axis_tdata,
  // [2:0] kind
  input  logic [2:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] run_mode, [2] cv_active, [18:3] upper_limit, [34:19] lower_limit,
  // [37:35] fault_code, [39:38] command_status, [56:40] active_target,
  // [68:57] trim_value, [71:69] zero
  output logic [cccv_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [15:0]                   cfg_data_i
);
  import cccv_pkg::*;

  // configuration
  logic [12:0]        vt_q, sv_q;
  logic signed [15:0] sc_q;
  logic signed [10:0] mt_q;

  // input stage
  logic               in_vld_q;
  logic [2:0]         in_kind_q;
  logic [15:0]        in_v_q;
  logic signed [15:0] in_m_q, in_r_q;

  // output stage
  logic                in_adv;
  logic                out_vld_q;
  logic [OutDataW-1:0] out_q, out_d;

  // controller state
  mode_e              st_q, st_d;
  logic signed [17:0] tgt_q;
  logic signed [15:0] spt_q;
  logic signed [11:0] trim_q;
  logic [4:0]         settle_q, settle_d;
  logic [15:0]        up_q, lo_q;
  fault_e             flt_q, flt_d;
  logic               cv_q, cv_d;

  // working values
  calc_t   v_w, m_w, r_w, vt_w, sv_w, sc_w, mt_w;
  calc_t   tgt, spt, trim, up, lo, val, dlt, off_up, off_lo;
  logic    skip, mbad;
  status_e sts;

  assign in_adv        = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | in_adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= VoltTargetRst;
      sv_q <= '0;
      sc_q <= '0;
      mt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VOLT_TARGET: vt_q <= cfg_data_i[12:0];
        CFG_STOP_VOLT:   sv_q <= cfg_data_i[12:0];
        CFG_STOP_CUR:    sc_q <= cfg_data_i;
        CFG_MID_TRIM:    mt_q <= cfg_data_i[10:0];
        default:         vt_q <= vt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= s_axis_tuser;
      in_v_q    <= s_axis_tdata[15:0];
      in_m_q    <= s_axis_tdata[31:16];
      in_r_q    <= s_axis_tdata[47:32];
    end
  end

  always_comb begin
    v_w    = calc_t'({4'b0, in_v_q});
    m_w    = calc_t'({{4{in_m_q[15]}}, in_m_q});
    r_w    = calc_t'({{4{in_r_q[15]}}, in_r_q});
    vt_w   = calc_t'({7'b0, vt_q});
    sv_w   = calc_t'({7'b0, sv_q});
    sc_w   = calc_t'({{4{sc_q[15]}}, sc_q});
    mt_w   = calc_t'({{9{mt_q[10]}}, mt_q});
    off_up = MidPoint + mt_w + IdleSpan;
    off_lo = MidPoint + mt_w - IdleSpan;
    mbad   = (mt_w < -MTrimLim) || (mt_w > MTrimLim);

    st_d     = st_q;
    tgt      = calc_t'({{2{tgt_q[17]}}, tgt_q});
    spt      = calc_t'({{4{spt_q[15]}}, spt_q});
    trim     = calc_t'({{8{trim_q[11]}}, trim_q});
    settle_d = settle_q;
    up       = calc_t'({4'b0, up_q});
    lo       = calc_t'({4'b0, lo_q});
    flt_d    = flt_q;
    cv_d     = cv_q;
    sts      = STS_NO_CMD;
    skip     = 1'b0;
    val      = '0;
    dlt      = '0;

    if (st_q != MODE_FAULT) begin
      case (kind_e'(in_kind_q))
        KIND_TICK: begin
          if (st_q == MODE_CHA) begin
            if (v_w > vt_w + Deadband) begin
              tgt = tgt - (v_w - vt_w);
              // target crossed zero: switch off, no fault
              if (tgt < 0) begin
                skip = 1'b1;
              end
            end else if (v_w < vt_w - Deadband && tgt < spt) begin
              tgt = tgt + (vt_w - v_w);
              if (tgt >= spt) begin
                tgt = spt;
              end
            end
          end else if (st_q == MODE_DSCH) begin
            if (v_w < vt_w - Deadband) begin
              tgt = tgt + (vt_w - v_w);
              if (tgt > 0) begin
                skip = 1'b1;
              end
            end else if (v_w > vt_w + Deadband && tgt > spt) begin
              tgt = tgt - (v_w - vt_w);
              if (tgt <= spt) begin
                tgt = spt;
              end
            end
          end
          if (st_q == MODE_CHA || st_q == MODE_DSCH) begin
            if (skip) begin
              st_d = MODE_OFF; up = off_up; lo = off_lo; trim = '0;
              settle_d = SettleReload;
            end else if ((st_q == MODE_CHA && (tgt > spt || tgt < 0)) ||
                         (st_q == MODE_DSCH && (tgt < spt || tgt > 0))) begin
              st_d  = MODE_FAULT;
              flt_d = (st_q == MODE_CHA) ? FLT_CHA_LOOP : FLT_DSCH_LOOP;
              up    = MidPoint + FaultSpan;
              lo    = MidPoint - FaultSpan;
            end else begin
              // trim integrates only after the settle count runs out
              if (settle_q != '0) begin
                settle_d = settle_q - 5'd1;
              end else if (m_w > tgt) begin
                dlt  = (m_w - tgt) >>> TrimShift;
                trim = trim - dlt;
                if (trim < TrimMin) begin
                  trim = TrimMin;
                end
              end else if (m_w < tgt) begin
                dlt  = (tgt - m_w) >>> TrimShift;
                trim = trim + dlt;
                if (trim > TrimMax) begin
                  trim = TrimMax;
                end
              end
              cv_d = (tgt != spt);
              if ((st_q == MODE_CHA && (tgt <= sc_w || v_w >= sv_w)) ||
                  (st_q == MODE_DSCH && (tgt >= sc_w || v_w <= sv_w))) begin
                st_d = MODE_OFF; up = off_up; lo = off_lo; trim = '0;
                settle_d = SettleReload;
              end
            end
          end
        end
        KIND_START_CHA, KIND_START_DSCH, KIND_STOP: begin
          st_d = MODE_OFF; up = off_up; lo = off_lo; trim = '0;
          settle_d = SettleReload;
          sts = STS_OK;
          if (kind_e'(in_kind_q) == KIND_START_CHA) begin
            if (spt <= 0 || spt > MaxPosI) begin
              sts = STS_PARAM;
            end else begin
              tgt  = spt;
              st_d = MODE_CHA;
            end
          end else if (kind_e'(in_kind_q) == KIND_START_DSCH) begin
            if (spt >= 0 || spt < MinNegI) begin
              sts = STS_PARAM;
            end else begin
              tgt  = spt;
              st_d = MODE_DSCH;
            end
          end
        end
        KIND_SET_CUR: begin
          if (r_w < -ReqLim || r_w > ReqLim) begin
            sts = STS_PARAM;
          end else if ((st_q == MODE_DSCH && r_w > 0) || (st_q == MODE_CHA && r_w < 0)) begin
            sts = STS_SIGN;
          end else begin
            spt = r_w;
            if ((st_q == MODE_DSCH && tgt < r_w) || (st_q == MODE_CHA && tgt > r_w)) begin
              tgt = r_w;
            end
            settle_d = SettleReload;
            sts      = STS_OK;
          end
        end
        default: sts = STS_NO_CMD;
      endcase

      // recompute comparator levels for the running side
      val = MidPoint + mt_w + tgt + trim;
      if (st_d == MODE_CHA) begin
        if (tgt < 0 || tgt > MaxPosI) begin
          st_d = MODE_FAULT; flt_d = FLT_CHA_RANGE;
          up = MidPoint + FaultSpan; lo = MidPoint - FaultSpan;
        end else if (mbad || val < MidPoint - MTrimLim || val > MidPoint + MaxPosI) begin
          st_d = MODE_FAULT; flt_d = FLT_CHA_LEVEL;
          up = MidPoint + FaultSpan; lo = MidPoint - FaultSpan;
        end else begin
          up = val;
          lo = off_lo;
        end
      end else if (st_d == MODE_DSCH) begin
        if (tgt > 0 || tgt < MinNegI) begin
          st_d = MODE_FAULT; flt_d = FLT_DSCH_RANGE;
          up = MidPoint + FaultSpan; lo = MidPoint - FaultSpan;
        end else if (mbad || val < MidPoint + MinNegI || val > MidPoint + MTrimLim) begin
          st_d = MODE_FAULT; flt_d = FLT_DSCH_LEVEL;
          up = MidPoint + FaultSpan; lo = MidPoint - FaultSpan;
        end else begin
          lo = val;
          up = off_up;
        end
      end
    end

    out_d = {3'b0, trim[11:0], tgt[16:0], sts, flt_d, lo[15:0], up[15:0], cv_d, st_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= MODE_OFF;
      tgt_q     <= '0;
      spt_q     <= '0;
      trim_q    <= '0;
      settle_q  <= SettleReload;
      up_q      <= 16'(MidPoint + IdleSpan);
      lo_q      <= 16'(MidPoint - IdleSpan);
      flt_q     <= FLT_NONE;
      cv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) begin
        st_q      <= st_d;
        tgt_q     <= tgt[17:0];
        spt_q     <= spt[15:0];
        trim_q    <= trim[11:0];
        settle_q  <= settle_d;
        up_q      <= up[15:0];
        lo_q      <= lo[15:0];
        flt_q     <= flt_d;
        cv_q      <= cv_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      out_q <= out_d;
    end
  end

  `CCCV_ASSERT_NEXT(a_fault_sticky, st_q == MODE_FAULT, st_q == MODE_FAULT, "fault state left")
  `CCCV_ASSERT(a_fault_code, (st_q == MODE_FAULT) == (flt_q != FLT_NONE), "fault code mismatch")
  `CCCV_ASSERT(a_trim_range, (trim_q >= -12'sd2000) && (trim_q <= 12'sd2000), "trim out of range")
  `CCCV_ASSERT(a_settle_range, settle_q <= SettleReload, "settle count above reload")
  `CCCV_ASSERT_NEXT(a_in_hold, in_vld_q && !in_adv, in_vld_q, "pending request dropped")

endmodule

@@ tb/sv/tb_cccv_battery_current_controller_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the CC/CV charge and discharge controller
module tb_cccv_battery_current_controller_top;
  import cccv_pkg::*;

  localparam int Mid         = 31768;
  localparam int PosLim      = 29000;
  localparam int NegLim      = -29000;
  localparam int TrimHi      = 2000;
  localparam int TrimLo      = -2000;
  localparam int OffsetLim   = 1000;
  localparam int IdleDelta   = 2000;
  localparam int FaultDelta  = 1000;
  localparam int Band        = 2;
  localparam int ReqMax      = 25000;
  localparam int SettleTicks = 20;
  localparam int ErrShift    = 3;
  localparam int CycleLimit  = 200000;
  localparam int NumSessions = 30;
  localparam int SessionLen  = 48;
  localparam int HoldCycles  = 60;
  localparam int IdlePct     = 22;

  // kinds beyond the defined commands, treated as no command
  localparam logic [2:0] KindSpareLo = 3'd5;
  localparam logic [2:0] KindSpareHi = 3'd7;

  typedef struct {
    mode_e       mode;
    logic        cv;
    logic [15:0] upper;
    logic [15:0] lower;
    fault_e      fault;
    status_e     status;
    logic [16:0] target;
    logic [11:0] trim;
  } ctrl_out_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [15:0] measured_voltage, [31:16] measured_current, [47:32] current_request
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // [2:0] kind
  logic [2:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [1:0] run_mode, [2] cv_active, [18:3] upper_limit, [34:19] lower_limit,
  // [37:35] fault_code, [39:38] command_status, [56:40] active_target,
  // [68:57] trim_value, [71:69] zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [15:0]         cfg_data_i = '0;

  cccv_battery_current_controller_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // controller image: registers and run state
  int      cfg_vtarget = 3300;
  int      cfg_vstop = 0;
  int      cfg_istop = 0;
  int      cfg_zero_trim = 0;
  mode_e   ctrl_mode = MODE_OFF;
  int      i_target = 0;
  int      cur_setpoint = 0;
  int      i_trim = 0;
  int      settle_left = SettleTicks;
  int      lvl_hi = Mid + IdleDelta;
  int      lvl_lo = Mid - IdleDelta;
  fault_e  fault_held = FLT_NONE;
  logic    cv_seen = 1'b0;

  ctrl_out_t awaited_outputs[$];
  ctrl_out_t want;
  int        n_errors = 0;
  int        n_checked = 0;
  int        n_sent = 0;
  int        n_settings = 0;
  int        n_cha_runs = 0;
  int        n_dsch_runs = 0;
  int        cycle_cnt = 0;
  int        stall_left = 0;
  bit        no_idle = 1'b0;

  function automatic void switch_off();
    ctrl_mode = MODE_OFF;
    lvl_hi = Mid + cfg_zero_trim + IdleDelta;
    lvl_lo = Mid + cfg_zero_trim - IdleDelta;
    i_trim = 0;
    settle_left = SettleTicks;
  endfunction

  function automatic void latch_fault(fault_e code);
    ctrl_mode = MODE_FAULT;
    fault_held = code;
    lvl_hi = Mid + FaultDelta;
    lvl_lo = Mid - FaultDelta;
  endfunction

  function automatic void trim_update(int meas);
    if (settle_left != 0) begin
      settle_left--;
      return;
    end
    if (meas > i_target) begin
      i_trim -= (meas - i_target) >>> ErrShift;
      if (i_trim < TrimLo) i_trim = TrimLo;
    end else if (meas < i_target) begin
      i_trim += (i_target - meas) >>> ErrShift;
      if (i_trim > TrimHi) i_trim = TrimHi;
    end
  endfunction

  function automatic void charge_tick(int v, int meas);
    if (v > cfg_vtarget + Band) begin
      i_target -= v - cfg_vtarget;
      // target crossing zero ends the run without a fault
      if (i_target < 0) begin
        switch_off();
        return;
      end
    end else if (v < cfg_vtarget - Band && i_target < cur_setpoint) begin
      i_target += cfg_vtarget - v;
      if (i_target >= cur_setpoint) i_target = cur_setpoint;
    end
    if (i_target > cur_setpoint || i_target < 0) begin
      latch_fault(FLT_CHA_LOOP);
      return;
    end
    trim_update(meas);
    cv_seen = (i_target != cur_setpoint);
    if (i_target <= cfg_istop || v >= cfg_vstop) switch_off();
  endfunction

  function automatic void discharge_tick(int v, int meas);
    if (v < cfg_vtarget - Band) begin
      i_target += cfg_vtarget - v;
      if (i_target > 0) begin
        switch_off();
        return;
      end
    end else if (v > cfg_vtarget + Band && i_target > cur_setpoint) begin
      i_target -= v - cfg_vtarget;
      if (i_target <= cur_setpoint) i_target = cur_setpoint;
    end
    if (i_target < cur_setpoint || i_target > 0) begin
      latch_fault(FLT_DSCH_LOOP);
      return;
    end
    trim_update(meas);
    cv_seen = (i_target != cur_setpoint);
    if (i_target >= cfg_istop || v <= cfg_vstop) switch_off();
  endfunction

  function automatic void refresh_levels();
    int lvl;
    bit zero_bad;
    zero_bad = (cfg_zero_trim < -OffsetLim || cfg_zero_trim > OffsetLim);
    if (ctrl_mode == MODE_CHA) begin
      if (i_target < 0 || i_target > PosLim) begin
        latch_fault(FLT_CHA_RANGE);
        return;
      end
      lvl = Mid + cfg_zero_trim + i_target + i_trim;
      if (zero_bad || lvl < Mid - OffsetLim || lvl > Mid + PosLim) begin
        latch_fault(FLT_CHA_LEVEL);
        return;
      end
      lvl_hi = lvl;
      lvl_lo = Mid + cfg_zero_trim - IdleDelta;
    end else if (ctrl_mode == MODE_DSCH) begin
      if (i_target > 0 || i_target < NegLim) begin
        latch_fault(FLT_DSCH_RANGE);
        return;
      end
      lvl = Mid + cfg_zero_trim + i_target + i_trim;
      if (zero_bad || lvl < Mid + NegLim || lvl > Mid + OffsetLim) begin
        latch_fault(FLT_DSCH_LEVEL);
        return;
      end
      lvl_lo = lvl;
      lvl_hi = Mid + cfg_zero_trim + IdleDelta;
    end
  endfunction

  function automatic ctrl_out_t controller_response(logic [2:0] kind, logic [15:0] v_raw,
                                                    logic [15:0] i_raw, logic [15:0] r_raw);
    int        v;
    int        meas;
    int        req;
    status_e   sts;
    ctrl_out_t res;
    v = int'(v_raw);
    meas = int'($signed(i_raw));
    req = int'($signed(r_raw));
    sts = STS_NO_CMD;
    if (ctrl_mode != MODE_FAULT) begin
      case (kind)
        KIND_TICK: begin
          if (ctrl_mode == MODE_CHA) charge_tick(v, meas);
          else if (ctrl_mode == MODE_DSCH) discharge_tick(v, meas);
        end
        KIND_START_CHA: begin
          switch_off();
          if (cur_setpoint <= 0 || cur_setpoint > PosLim) begin
            sts = STS_PARAM;
          end else begin
            sts = STS_OK;
            i_target = cur_setpoint;
            ctrl_mode = MODE_CHA;
          end
        end
        KIND_START_DSCH: begin
          switch_off();
          if (cur_setpoint >= 0 || cur_setpoint < NegLim) begin
            sts = STS_PARAM;
          end else begin
            sts = STS_OK;
            i_target = cur_setpoint;
            ctrl_mode = MODE_DSCH;
          end
        end
        KIND_STOP: begin
          switch_off();
          sts = STS_OK;
        end
        KIND_SET_CUR: begin
          if (req < -ReqMax || req > ReqMax) begin
            sts = STS_PARAM;
          end else if ((ctrl_mode == MODE_DSCH && req > 0) ||
                       (ctrl_mode == MODE_CHA && req < 0)) begin
            sts = STS_SIGN;
          end else begin
            cur_setpoint = req;
            if ((ctrl_mode == MODE_DSCH && i_target < req) ||
                (ctrl_mode == MODE_CHA && i_target > req))
              i_target = req;
            settle_left = SettleTicks;
            sts = STS_OK;
          end
        end
        default: ;
      endcase
      if (ctrl_mode != MODE_FAULT) refresh_levels();
    end
    res.mode = ctrl_mode;
    res.cv = cv_seen;
    res.upper = lvl_hi[15:0];
    res.lower = lvl_lo[15:0];
    res.fault = fault_held;
    res.status = sts;
    res.target = i_target[16:0];
    res.trim = i_trim[11:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("result %0d: %s got 0x%0h, expected 0x%0h", n_checked, what, got, exp_val);
    n_errors++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_outputs.size() == 0) begin
        report_mismatch("result with nothing awaited", m_axis_tdata[31:0], '0);
      end else begin
        want = awaited_outputs.pop_front();
        check_field("run_mode", 32'(m_axis_tdata[1:0]), 32'(want.mode));
        check_field("cv_active", 32'(m_axis_tdata[2]), 32'(want.cv));
        check_field("upper_limit", 32'(m_axis_tdata[18:3]), 32'(want.upper));
        check_field("lower_limit", 32'(m_axis_tdata[34:19]), 32'(want.lower));
        check_field("fault_code", 32'(m_axis_tdata[37:35]), 32'(want.fault));
        check_field("command_status", 32'(m_axis_tdata[39:38]), 32'(want.status));
        check_field("active_target", 32'(m_axis_tdata[56:40]), 32'(want.target));
        check_field("trim_value", 32'(m_axis_tdata[68:57]), 32'(want.trim));
      end
      n_checked++;
    end
  end

  // result receiver: random back-pressure, long hold on demand
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results awaited", cycle_cnt,
               awaited_outputs.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_request(input logic [2:0] kind, input logic [15:0] volt,
                              input logic [15:0] amp, input logic [15:0] req);
    ctrl_out_t res;
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {req, amp, volt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = controller_response(kind, volt, amp, req);
    if (res.status == STS_OK && kind == KIND_START_CHA) n_cha_runs++;
    if (res.status == STS_OK && kind == KIND_START_DSCH) n_dsch_runs++;
    awaited_outputs.push_back(res);
    n_sent++;
  endtask

  task automatic send_tick(input int volt, input int amp);
    send_request(KIND_TICK, volt[15:0], amp[15:0], 16'($urandom));
  endtask

  task automatic send_cmd(input kind_e kind);
    send_request(kind, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_set_current(input int amps);
    send_request(KIND_SET_CUR, 16'($urandom), 16'($urandom), amps[15:0]);
  endtask

  // hold the sender until every result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_VOLT_TARGET: cfg_vtarget = int'(val[12:0]);
      CFG_STOP_VOLT:   cfg_vstop = int'(val[12:0]);
      CFG_STOP_CUR:    cfg_istop = int'($signed(val));
      CFG_MID_TRIM:    cfg_zero_trim = int'($signed(val[10:0]));
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int vtarget, input int vstop, input int istop,
                                input int zero_trim);
    wait_drained();
    write_reg(CFG_VOLT_TARGET, vtarget[15:0]);
    write_reg(CFG_STOP_VOLT, vstop[15:0]);
    write_reg(CFG_STOP_CUR, istop[15:0]);
    write_reg(CFG_MID_TRIM, zero_trim[15:0]);
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    n_settings++;
  endtask

  // reset settings: field extremes, bad setpoints, bad requests, stop voltage zero
  task automatic test_idle_commands();
    send_request(KIND_TICK, 16'hFFFF, 16'h8000, 16'h7FFF);
    send_request(KindSpareHi, 16'h0000, 16'h7FFF, 16'h8000);
    send_cmd(KIND_START_CHA);
    send_cmd(KIND_START_DSCH);
    send_set_current(ReqMax + 1);
    send_set_current(-32768);
    send_set_current(10000);
    send_cmd(KIND_START_CHA);
    send_tick(3300, 10000);
    send_cmd(KIND_STOP);
  endtask

  task automatic test_charge_loop();
    apply_settings(4500, 5000, 3000, 1000);
    send_cmd(KIND_START_CHA);
    send_set_current(-5000);
    send_set_current(20000);
    send_tick(4000, 12000);
    send_tick(4500, -32768);
    send_tick(4800, 0);
    send_tick(65535, 0);
  endtask

  task automatic test_discharge_loop();
    apply_settings(0, 0, -ReqMax, -1000);
    send_set_current(-20000);
    send_cmd(KIND_START_DSCH);
    send_set_current(100);
    send_tick(0, 32767);
    apply_settings(3000, 1000, -3000, -1000);
    send_cmd(KIND_START_DSCH);
    send_tick(2000, -20000);
    send_tick(5000, -19000);
    send_set_current(-2000);
    send_tick(0, 0);
  endtask

  // one setting, one direction: set current, start, then mostly ticks near the setpoint
  task automatic run_session(input bit charge, input int len, input bit hold);
    int vt;
    int vs;
    int dir;
    int bias;
    int pick;
    int amp;
    int mag;
    dir = charge ? 1 : -1;
    vt = $urandom_range(4500, 1500);
    if (charge) begin
      vs = vt + int'($urandom_range(700, 300));
      if (vs > 5000) vs = 5000;
    end else begin
      vs = vt - int'($urandom_range(700, 300));
    end
    apply_settings(vt, vs, dir * int'($urandom_range(6000, 3000)),
                   int'($urandom_range(1000)) - 500);
    bias = int'($urandom_range(6000)) - 3000;
    send_set_current(dir * int'($urandom_range(ReqMax, 8000)));
    send_cmd(charge ? KIND_START_CHA : KIND_START_DSCH);
    if (hold) stall_left = HoldCycles;
    repeat (len) begin
      pick = $urandom_range(99);
      if (ctrl_mode == MODE_OFF && pick < 40) begin
        send_cmd(charge ? KIND_START_CHA : KIND_START_DSCH);
      end else if (pick < 78) begin
        amp = i_target + bias + int'($urandom_range(8000)) - 4000;
        if (amp > 32767) amp = 32767;
        if (amp < -32768) amp = -32768;
        send_tick(vt + int'($urandom_range(500)) - 250, amp);
      end else if (pick < 83) begin
        send_set_current(dir * int'($urandom_range(ReqMax, 3500)));
      end else if (pick < 86 && ctrl_mode != MODE_OFF) begin
        send_set_current(-dir * int'($urandom_range(ReqMax, 1)));
      end else if (pick < 89) begin
        mag = $urandom_range(32768, ReqMax + 1);
        send_set_current($urandom_range(1) ? mag : -mag);
      end else if (pick < 92) begin
        send_request(3'($urandom_range(KindSpareHi, KindSpareLo)), 16'($urandom),
                     16'($urandom), 16'($urandom));
      end else if (pick < 96) begin
        send_request(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 98) begin
        send_cmd(KIND_STOP);
      end else begin
        send_set_current(dir * int'($urandom_range(ReqMax, 8000)));
        send_cmd(charge ? KIND_START_CHA : KIND_START_DSCH);
      end
    end
  endtask

  task automatic test_random_sessions();
    for (int s = 0; s < NumSessions; s++) begin
      no_idle = (s == 4);
      run_session(s % 2 == 0, SessionLen, s == 8);
    end
    no_idle = 1'b0;
  endtask

  // zero trim out of range faults a charge start; everything after is ignored
  task automatic test_fault_latch();
    apply_settings(3300, 5000, ReqMax, 1023);
    send_cmd(KIND_STOP);
    send_set_current(5000);
    send_cmd(KIND_START_CHA);
    send_tick(3300, 5000);
    send_cmd(KIND_STOP);
    send_cmd(KIND_START_DSCH);
    send_set_current(1000);
    send_request(KindSpareLo, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_commands();
    test_charge_loop();
    test_discharge_loop();
    test_random_sessions();
    test_fault_latch();
    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("%0d requests sent, %0d results checked under %0d register settings",
             n_sent, n_checked, n_settings);
    $display("%0d charge and %0d discharge runs started, fault latch exercised at the end",
             n_cha_runs, n_dsch_runs);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
